>>> hdl/blr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  localparam int COORD_WIDTH = 9;
  localparam int DIM_WIDTH   = 9;
  localparam int COLOR_WIDTH = 16;
  localparam int DELTA_WIDTH = COORD_WIDTH + 1;
  localparam int ERR_WIDTH   = COORD_WIDTH + 3;
  localparam int E2_WIDTH    = ERR_WIDTH + 1;
  localparam int CMP_WIDTH   = (COORD_WIDTH > DIM_WIDTH) ? COORD_WIDTH : DIM_WIDTH;

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;

  localparam logic [DIM_WIDTH-1:0] SCREEN_WIDTH_RESET  = DIM_WIDTH'(240);
  localparam logic [DIM_WIDTH-1:0] SCREEN_HEIGHT_RESET = DIM_WIDTH'(320);

  typedef enum logic {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_sel_t;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef struct packed {
    logic                   op;
    logic [COORD_WIDTH-1:0] start_x;
    logic [COORD_WIDTH-1:0] start_y;
    logic [COORD_WIDTH-1:0] end_x;
    logic [COORD_WIDTH-1:0] end_y;
    logic [COLOR_WIDTH-1:0] line_color;
  } cmd_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] pixel_x;
    logic [COORD_WIDTH-1:0] pixel_y;
    logic [COLOR_WIDTH-1:0] pixel_color;
    logic                   pixel_valid;
    logic                   last_pixel;
  } pix_t;

endpackage

`default_nettype wire

>>> hdl/bresenham_line_rasterizer_unit.sv
// Bresenham line rasterizer. A start transaction on cmd loads two endpoints and a color
// and returns the first endpoint; each advance transaction returns the next pixel of the
// line, with last_pixel set on the second endpoint. Off-screen pixels (against the
// screen_width and screen_height registers at APB byte addresses 0 and 4) come out with
// pixel_valid low; an advance with no line in progress returns an all-zero pixel. Every
// command yields exactly one pixel transaction. A command is handled in the cycle it is
// accepted: the line state and the pixel output register both load at that edge, so the
// pixel appears in the next cycle. The single output register sets the rate: one
// command per clock while pix is not stalled, and cmd stalls while a pixel waits on pix.
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer_unit
  import blr_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst,

  input  wire                       cmd_valid,
  output logic                      cmd_stall,
  input  cmd_t                      cmd,

  output logic                      pix_valid,
  input  wire                       pix_stall,
  output pix_t                      pix,

  input  wire                       psel,
  input  wire                       penable,
  input  wire                       pwrite,
  input  wire  [APB_ADDR_WIDTH-1:0] paddr,
  input  wire  [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic [DIM_WIDTH-1:0] screen_width;
  logic [DIM_WIDTH-1:0] screen_height;
  reg_sel_t             reg_sel;

  logic [COORD_WIDTH-1:0]      cur_x, cur_x_next;
  logic [COORD_WIDTH-1:0]      cur_y, cur_y_next;
  logic [COORD_WIDTH-1:0]      target_x, target_x_next;
  logic [COORD_WIDTH-1:0]      target_y, target_y_next;
  logic [DELTA_WIDTH-1:0]      delta_x, delta_x_next;
  logic [DELTA_WIDTH-1:0]      delta_y, delta_y_next;
  logic                        step_neg_x, step_neg_x_next;
  logic                        step_neg_y, step_neg_y_next;
  logic signed [ERR_WIDTH-1:0] error_acc, error_acc_next;
  logic [COLOR_WIDTH-1:0]      held_color, held_color_next;
  logic                        line_active, line_active_next;

  logic                        cmd_fire;
  pix_t                        pix_next;
  logic signed [E2_WIDTH-1:0]  e2;
  logic signed [E2_WIDTH-1:0]  dx_ext;
  logic signed [E2_WIDTH-1:0]  dy_ext;
  logic signed [E2_WIDTH-1:0]  err_sum;
  logic                        move_x;
  logic                        move_y;
  logic                        at_end;
  logic                        on_screen;

  assign reg_sel = reg_sel_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[DIM_WIDTH-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[DIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = APB_DATA_WIDTH'(screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DATA_WIDTH'(screen_height);
      default:           prdata = '0;
    endcase
  end

  assign cmd_stall = pix_valid && pix_stall;
  assign cmd_fire  = cmd_valid && !cmd_stall;

  assign e2     = E2_WIDTH'(error_acc) <<< 1;
  assign dx_ext = $signed(E2_WIDTH'(delta_x));
  assign dy_ext = $signed(E2_WIDTH'(delta_y));
  assign move_x = (e2 > -dy_ext) && (cur_x != target_x);
  assign move_y = (e2 < dx_ext) && (cur_y != target_y);

  always_comb begin
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    target_x_next    = target_x;
    target_y_next    = target_y;
    delta_x_next     = delta_x;
    delta_y_next     = delta_y;
    step_neg_x_next  = step_neg_x;
    step_neg_y_next  = step_neg_y;
    error_acc_next   = error_acc;
    held_color_next  = held_color;
    line_active_next = line_active;
    err_sum          = E2_WIDTH'(error_acc);
    pix_next         = '0;
    at_end           = 1'b0;
    on_screen        = 1'b0;

    if (cmd.op == OP_START) begin
      cur_x_next      = cmd.start_x;
      cur_y_next      = cmd.start_y;
      target_x_next   = cmd.end_x;
      target_y_next   = cmd.end_y;
      held_color_next = cmd.line_color;
      step_neg_x_next = cmd.end_x < cmd.start_x;
      step_neg_y_next = cmd.end_y < cmd.start_y;
      delta_x_next    = step_neg_x_next ? DELTA_WIDTH'(cmd.start_x - cmd.end_x)
                                        : DELTA_WIDTH'(cmd.end_x - cmd.start_x);
      delta_y_next    = step_neg_y_next ? DELTA_WIDTH'(cmd.start_y - cmd.end_y)
                                        : DELTA_WIDTH'(cmd.end_y - cmd.start_y);
      error_acc_next  = $signed(ERR_WIDTH'(delta_x_next)) - $signed(ERR_WIDTH'(delta_y_next));
    end else if (line_active) begin
      if (move_x) begin
        err_sum    = err_sum - dy_ext;
        cur_x_next = step_neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        err_sum    = err_sum + dx_ext;
        cur_y_next = step_neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      error_acc_next = err_sum[ERR_WIDTH-1:0];
    end

    if (cmd.op == OP_START || line_active) begin
      at_end    = (cur_x_next == target_x_next) && (cur_y_next == target_y_next);
      on_screen = (CMP_WIDTH'(cur_x_next) < CMP_WIDTH'(screen_width)) &&
                  (CMP_WIDTH'(cur_y_next) < CMP_WIDTH'(screen_height));
      line_active_next     = !at_end;
      pix_next.pixel_x     = cur_x_next;
      pix_next.pixel_y     = cur_y_next;
      pix_next.pixel_color = held_color_next;
      pix_next.pixel_valid = on_screen;
      pix_next.last_pixel  = at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      target_x    <= '0;
      target_y    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      step_neg_x  <= 1'b0;
      step_neg_y  <= 1'b0;
      error_acc   <= '0;
      held_color  <= '0;
      line_active <= 1'b0;
    end else if (cmd_fire) begin
      cur_x       <= cur_x_next;
      cur_y       <= cur_y_next;
      target_x    <= target_x_next;
      target_y    <= target_y_next;
      delta_x     <= delta_x_next;
      delta_y     <= delta_y_next;
      step_neg_x  <= step_neg_x_next;
      step_neg_y  <= step_neg_y_next;
      error_acc   <= error_acc_next;
      held_color  <= held_color_next;
      line_active <= line_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (cmd_fire) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pix <= pix_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/blr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module blr_checker
  import blr_pkg::*;
(
  input wire  clk,
  input wire  rst,
  input wire  cmd_valid,
  input wire  cmd_stall,
  input cmd_t cmd,
  input wire  pix_valid,
  input wire  pix_stall,
  input pix_t pix
);

  logic cmd_fire;
  logic single_point;

  assign cmd_fire     = cmd_valid && !cmd_stall;
  assign single_point = (cmd.op == OP_START) && (cmd.start_x == cmd.end_x) &&
                        (cmd.start_y == cmd.end_y);

  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pix))
    else $error("pixel transaction changed while stalled");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> pix_valid)
    else $error("accepted command gave no pixel transaction");

  a_start_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.op == OP_START |=>
      pix.pixel_x == $past(cmd.start_x) && pix.pixel_y == $past(cmd.start_y) &&
      pix.pixel_color == $past(cmd.line_color))
    else $error("start pixel does not match first endpoint");

  a_single_point: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && single_point |=> pix.last_pixel)
    else $error("single-point line not flagged as last");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.op == OP_ADVANCE && pix.last_pixel
      |=> !pix.last_pixel && !pix.pixel_valid)
    else $error("advance after last pixel did not return an idle pixel");

endmodule

bind bresenham_line_rasterizer_unit blr_checker u_blr_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .cmd       (cmd),
  .pix_valid (pix_valid),
  .pix_stall (pix_stall),
  .pix       (pix)
);

`default_nettype wire

>>> verif/bresenham_line_rasterizer_unit_tb.sv
`timescale 1ns / 1ps

module bresenham_line_rasterizer_unit_tb;
  import blr_pkg::*;

  localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;

  logic pix_valid;
  logic pix_stall = 1'b0;
  pix_t pix;

  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  bresenham_line_rasterizer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #1 clk = ~clk;

  cmd_t pending_cmds[$];
  pix_t expected_pixels[$];
  int   queued = 0;
  int   pixel_errors = 0;
  int   cycles = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  bit   cmd_accepted = 1'b0;

  // line state mirrored from the block
  logic [DIM_WIDTH-1:0]   scr_w = SCREEN_WIDTH_RESET;
  logic [DIM_WIDTH-1:0]   scr_h = SCREEN_HEIGHT_RESET;
  logic [COORD_WIDTH-1:0] ln_x = '0, ln_y = '0, ln_tx = '0, ln_ty = '0;
  logic [DELTA_WIDTH-1:0] ln_dx = '0, ln_dy = '0;
  logic                   ln_neg_x = 1'b0, ln_neg_y = 1'b0;
  int                     ln_err = 0;
  logic [COLOR_WIDTH-1:0] ln_color = '0;
  bit                     ln_active = 1'b0;

  function automatic pix_t rasterize_step(cmd_t c);
    pix_t p;
    int   e2;
    bit   last;
    p = '0;
    if (c.op == OP_START) begin
      ln_x     = c.start_x;
      ln_y     = c.start_y;
      ln_tx    = c.end_x;
      ln_ty    = c.end_y;
      ln_color = c.line_color;
      ln_neg_x = ln_tx < ln_x;
      ln_neg_y = ln_ty < ln_y;
      ln_dx    = ln_neg_x ? ln_x - ln_tx : ln_tx - ln_x;
      ln_dy    = ln_neg_y ? ln_y - ln_ty : ln_ty - ln_y;
      ln_err   = int'(ln_dx) - int'(ln_dy);
    end else if (ln_active) begin
      e2 = 2 * ln_err;
      if (e2 > -int'(ln_dy) && ln_x != ln_tx) begin
        ln_err -= int'(ln_dy);
        ln_x = ln_neg_x ? ln_x - 1'b1 : ln_x + 1'b1;
      end
      if (e2 < int'(ln_dx) && ln_y != ln_ty) begin
        ln_err += int'(ln_dx);
        ln_y = ln_neg_y ? ln_y - 1'b1 : ln_y + 1'b1;
      end
    end else begin
      return p;
    end
    last          = (ln_x == ln_tx) && (ln_y == ln_ty);
    p.pixel_x     = ln_x;
    p.pixel_y     = ln_y;
    p.pixel_color = ln_color;
    p.pixel_valid = (ln_x < scr_w) && (ln_y < scr_h);
    p.last_pixel  = last;
    ln_active     = !last;
    return p;
  endfunction

  task automatic note_mismatch(string what, pix_t want, pix_t got);
    pixel_errors++;
    if (pixel_errors <= 10) begin
      $display("%0t %s: want x=%0d y=%0d c=%h v=%b l=%b got x=%0d y=%0d c=%h v=%b l=%b",
               $time, what, want.pixel_x, want.pixel_y, want.pixel_color, want.pixel_valid,
               want.last_pixel, got.pixel_x, got.pixel_y, got.pixel_color, got.pixel_valid,
               got.last_pixel);
    end
  endtask

  always @(posedge clk) begin
    pix_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("bresenham_line_rasterizer_unit_tb failed");
      $finish;
    end else if (rst) begin
      cmd_accepted = 1'b0;
    end else begin
      cmd_accepted = cmd_valid && !cmd_stall;
      if (cmd_accepted) begin
        expected_pixels.push_back(rasterize_step(cmd));
      end
      if (pix_valid && !pix_stall) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch("unexpected pixel", '0, pix);
        end else begin
          want = expected_pixels.pop_front();
          if (pix !== want) begin
            note_mismatch("pixel mismatch", want, pix);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_accepted) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
      pix_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic cmd_t random_cmd();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(cmd_t)-1:0];
  endfunction

  function automatic int clamp_coord(int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  task automatic queue_line(int sx, int sy, int ex, int ey, logic [COLOR_WIDTH-1:0] color,
                            int nadv);
    cmd_t c;
    c            = random_cmd();
    c.op         = OP_START;
    c.start_x    = COORD_WIDTH'(sx);
    c.start_y    = COORD_WIDTH'(sy);
    c.end_x      = COORD_WIDTH'(ex);
    c.end_y      = COORD_WIDTH'(ey);
    c.line_color = color;
    pending_cmds.push_back(c);
    repeat (nadv) begin
      c    = random_cmd();
      c.op = OP_ADVANCE;
      pending_cmds.push_back(c);
    end
    queued += 1 + nadv;
  endtask

  task automatic queue_random_line();
    int kind, sx, sy, ex, ey, span, steps, nadv;
    kind = $urandom_range(99);
    sx   = $urandom_range(COORD_MAX);
    sy   = $urandom_range(COORD_MAX);
    if (kind >= 95) begin
      repeat ($urandom_range(1, 3)) begin
        pending_cmds.push_back(random_cmd());
        queued++;
      end
      return;
    end
    if (kind >= 85) begin
      ex = $urandom_range(COORD_MAX);
      ey = $urandom_range(COORD_MAX);
    end else begin
      span = (kind < 70) ? 12 : 40;
      ex   = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
      ey   = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
    end
    if ($urandom_range(9) == 0) begin
      ex = sx;
    end else if ($urandom_range(9) == 0) begin
      ey = sy;
    end
    steps = (ex > sx) ? ex - sx : sx - ex;
    if (((ey > sy) ? ey - sy : sy - ey) > steps) begin
      steps = (ey > sy) ? ey - sy : sy - ey;
    end
    if (kind >= 85) begin
      nadv = $urandom_range(0, 24);
    end else if ($urandom_range(99) < 85) begin
      nadv = steps;
    end else begin
      nadv = $urandom_range(0, steps + 2);
    end
    queue_line(sx, sy, ex, ey, COLOR_WIDTH'($urandom_range(16'hFFFF)), nadv);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_screen_reg(reg_sel_t idx, logic [DIM_WIDTH-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_WIDTH'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) begin
      scr_w = value;
    end else begin
      scr_h = value;
    end
  endtask

  task automatic run_phase(int n_items, bit with_hold);
    int first, chunk_end;
    first = queued;
    while (queued - first < n_items) begin
      chunk_end = queued + $urandom_range(20, 60);
      while (queued < chunk_end) queue_random_line();
      if (with_hold) begin
        hold_requests++;
        with_hold = 1'b0;
      end
      wait_drained();
    end
  endtask

  initial begin
    int widths[PHASES];
    int heights[PHASES];
    widths  = '{COORD_MAX, 1, 0, $urandom_range(1, COORD_MAX), $urandom_range(1, COORD_MAX),
                COORD_MAX};
    heights = '{COORD_MAX, COORD_MAX, 0, $urandom_range(1, COORD_MAX),
                $urandom_range(1, COORD_MAX), 1};
    send_idle_pct = 31;
    recv_idle_pct = 85;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    queue_line(0, 0, 0, 0, 16'h0000, 1);
    queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'hFFFF, 0);
    queue_line(5, 7, 8, 7, 16'hF800, 3);
    queue_line(3, 9, 3, 6, 16'h07E0, 3);
    queue_line(10, 2, 8, 7, 16'h001F, 5);
    queue_line(238, 100, 242, 101, 16'h1234, 4);
    queue_line(0, 319, COORD_MAX, 0, 16'hABCD, 1);
    wait_drained();

    for (int k = 0; k < PHASES; k++) begin
      write_screen_reg(REG_SCREEN_WIDTH, DIM_WIDTH'(widths[k]));
      write_screen_reg(REG_SCREEN_HEIGHT, DIM_WIDTH'(heights[k]));
      if (k < 2) begin
        send_idle_pct = 31;
        recv_idle_pct = 85;
      end else if (k < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(80, k == 1 || k == 4);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (pixel_errors == 0 && expected_pixels.size() == 0) begin
      $display("bresenham_line_rasterizer_unit_tb passed");
    end else begin
      $display("bresenham_line_rasterizer_unit_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/blr_pkg.sv
hdl/bresenham_line_rasterizer_unit.sv
hdl/blr_checker.sv
verif/bresenham_line_rasterizer_unit_tb.sv
